/* rtl/sprc_pkg.sv */
// Shared types and constants of the scratch position rate controller.
package sprc_pkg;

    // Field widths
    localparam int POS_BITS      = 48;
    localparam int RATE_BITS     = 32;
    localparam int GAIN_BITS     = 32;
    localparam int DECAY_BITS    = 16;
    localparam int DBAND_BITS    = 31;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // Stream payload widths
    localparam int S_TDATA_BITS = 104;
    localparam int M_TDATA_BITS = 32;
    localparam int M_TUSER_BITS = 2;

    // Split multiplier: magnitude cut into a low word and a high part
    localparam int MAG_BITS  = POS_BITS + 1;
    localparam int MLO_BITS  = 32;
    localparam int MHI_BITS  = MAG_BITS - MLO_BITS;
    localparam int PLO_BITS  = MLO_BITS + GAIN_BITS;
    localparam int LO_BITS   = PLO_BITS - 16;
    localparam int HI_BITS   = MHI_BITS + GAIN_BITS;
    localparam int WSUM_BITS = HI_BITS + 17;

    // Thresholds (Q16.16)
    localparam int ERR_INTEG_MIN  = 6553;
    localparam int THROW_MIN      = 163840;
    localparam int THR_PLAYING    = 65536;
    localparam int THR_PAUSED_MAX = 655;

    // Input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SEEK = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NORM_SCALE    = 3'd0,
        CFG_GAIN_P        = 3'd1,
        CFG_GAIN_I        = 3'd2,
        CFG_GAIN_D        = 3'd3,
        CFG_DECAY_PAUSED  = 3'd4,
        CFG_DECAY_PLAYING = 3'd5,
        CFG_DEAD_BAND     = 3'd6
    } cfg_idx_t;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        MOP_TGT = 3'd0,
        MOP_TRV = 3'd1,
        MOP_P   = 3'd2,
        MOP_I   = 3'd3,
        MOP_D   = 3'd4,
        MOP_DEC = 3'd5
    } mul_op_t;

    // Controller states, one-hot
    typedef enum logic [18:0] {
        ST_IDLE     = 19'h00001,
        ST_DISPATCH = 19'h00002,
        ST_TGT_L    = 19'h00004,
        ST_TGT_H    = 19'h00008,
        ST_TRV_L    = 19'h00010,
        ST_TRV_H    = 19'h00020,
        ST_TRV_DONE = 19'h00040,
        ST_ERR      = 19'h00080,
        ST_P_L      = 19'h00100,
        ST_P_H      = 19'h00200,
        ST_I_L      = 19'h00400,
        ST_I_H      = 19'h00800,
        ST_D_L      = 19'h01000,
        ST_D_H      = 19'h02000,
        ST_SUM      = 19'h04000,
        ST_DEC_L    = 19'h08000,
        ST_DEC_H    = 19'h10000,
        ST_DEC_END  = 19'h20000,
        ST_OUT      = 19'h40000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load_in;
        logic    mul_lo;
        logic    mul_hi;
        mul_op_t mul_op;
        logic    init_scratch;
        logic    set_target;
        logic    upd_travel;
        logic    upd_err;
        logic    upd_accum;
        logic    psum_load;
        logic    psum_add;
        logic    finish_pid;
        logic    set_decay;
        logic    upd_last;
        logic    load_out;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic seek;
        logic enable;
        logic throw_rate;
        logic below;
    } dp_status_t;

endpackage

/* rtl/sprc_dpath.sv */
// Datapath: configuration registers, loop state, shared split multiplier.
module sprc_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sprc_pkg::ctrl_cmd_t                 cmd,
    output sprc_pkg::dp_status_t                status,
    input  logic [sprc_pkg::S_TDATA_BITS-1:0]   s_tdata,
    input  logic                                s_tuser,
    input  logic                                cfg_valid,
    input  logic [sprc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [sprc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output logic [sprc_pkg::M_TDATA_BITS-1:0]   out_rate
);

    localparam int RB = sprc_pkg::RATE_BITS;
    localparam int PB = sprc_pkg::POS_BITS;
    localparam int MB = sprc_pkg::MAG_BITS;

    localparam logic signed [RB+1:0] WMAX = signed'({3'b000, {(RB-1){1'b1}}});
    localparam logic signed [RB+1:0] WMIN = signed'({3'b111, {(RB-1){1'b0}}});
    localparam logic [sprc_pkg::WSUM_BITS-1:0] RMAX_W =
        {{(sprc_pkg::WSUM_BITS-RB+1){1'b0}}, {(RB-1){1'b1}}};
    localparam logic signed [RB-1:0] RMAX_S = signed'({1'b0, {(RB-1){1'b1}}});
    localparam logic signed [RB-1:0] RMIN_S = signed'({1'b1, {(RB-1){1'b0}}});

    // Saturate a widened sum to the rate range
    function automatic logic signed [RB-1:0] sat_rate(input logic signed [RB+1:0] x);
        logic signed [RB-1:0] r;
        if (x > WMAX) begin
            r = RMAX_S;
        end else if (x < WMIN) begin
            r = RMIN_S;
        end else begin
            r = x[RB-1:0];
        end
        return r;
    endfunction

    // Magnitude of a signed value
    function automatic logic [MB-1:0] mag_of(input logic signed [MB-1:0] v);
        logic [MB-1:0] m;
        m = v[MB-1] ? MB'(-v) : MB'(v);
        return m;
    endfunction

    function automatic logic [sprc_pkg::GAIN_BITS-1:0] gmag(
        input logic signed [sprc_pkg::GAIN_BITS-1:0] g);
        logic [sprc_pkg::GAIN_BITS-1:0] m;
        m = g[sprc_pkg::GAIN_BITS-1] ? sprc_pkg::GAIN_BITS'(-g)
                                     : sprc_pkg::GAIN_BITS'(g);
        return m;
    endfunction

    // Configuration registers
    logic [31:0]                           norm_scale_reg;
    logic signed [sprc_pkg::GAIN_BITS-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [sprc_pkg::DECAY_BITS-1:0]       decay_paused_reg, decay_playing_reg;
    logic [sprc_pkg::DBAND_BITS-1:0]       dead_band_reg;

    // Latched input transaction
    logic signed [PB-1:0] cur_reg, scr_reg;
    logic                 enable_reg, paused_reg, seek_reg;

    // Loop state
    logic signed [PB-1:0] last_reg, start_reg;
    logic signed [RB-1:0] travel_reg, rate_reg, prev_reg, accum_reg;
    logic signed [RB-1:0] target_reg, err_reg;
    logic signed [RB+1:0] psum_reg;
    logic [sprc_pkg::M_TDATA_BITS-1:0] out_reg;

    // Multiplier registers
    logic [sprc_pkg::LO_BITS-1:0]   lo_reg;
    logic [sprc_pkg::HI_BITS-1:0]   hi_reg;
    logic [sprc_pkg::MHI_BITS-1:0]  mhi_reg;
    logic [sprc_pkg::GAIN_BITS-1:0] g_reg;
    logic                           neg_reg, sel24_reg;

    // Multiplier operand selection
    logic [MB-1:0]                  op_m;
    logic [sprc_pkg::GAIN_BITS-1:0] op_g;
    logic                           op_neg, op_sel24;
    logic signed [MB-1:0]           d_scr, d_cur, e_ext, a_ext, dd_ext, r_ext;
    logic [sprc_pkg::DECAY_BITS-1:0] dec_sel;

    assign d_scr   = MB'(scr_reg) - MB'(start_reg);
    assign d_cur   = MB'(cur_reg) - MB'(last_reg);
    assign e_ext   = MB'(err_reg);
    assign a_ext   = MB'(accum_reg);
    assign dd_ext  = MB'(err_reg) - MB'(prev_reg);
    assign r_ext   = MB'(rate_reg);
    assign dec_sel = paused_reg ? decay_paused_reg : decay_playing_reg;

    always_comb begin
        unique case (cmd.mul_op)
            sprc_pkg::MOP_TGT: begin
                op_m = mag_of(d_scr); op_g = norm_scale_reg;
                op_neg = d_scr[MB-1]; op_sel24 = 1'b1;
            end
            sprc_pkg::MOP_TRV: begin
                op_m = mag_of(d_cur); op_g = norm_scale_reg;
                op_neg = d_cur[MB-1]; op_sel24 = 1'b1;
            end
            sprc_pkg::MOP_P: begin
                op_m = mag_of(e_ext); op_g = gmag(gain_p_reg);
                op_neg = e_ext[MB-1] ^ gain_p_reg[sprc_pkg::GAIN_BITS-1];
                op_sel24 = 1'b0;
            end
            sprc_pkg::MOP_I: begin
                op_m = mag_of(a_ext); op_g = gmag(gain_i_reg);
                op_neg = a_ext[MB-1] ^ gain_i_reg[sprc_pkg::GAIN_BITS-1];
                op_sel24 = 1'b0;
            end
            sprc_pkg::MOP_D: begin
                op_m = mag_of(dd_ext); op_g = gmag(gain_d_reg);
                op_neg = dd_ext[MB-1] ^ gain_d_reg[sprc_pkg::GAIN_BITS-1];
                op_sel24 = 1'b0;
            end
            sprc_pkg::MOP_DEC: begin
                op_m = mag_of(r_ext);
                op_g = {{(sprc_pkg::GAIN_BITS-sprc_pkg::DECAY_BITS){1'b0}}, dec_sel};
                op_neg = r_ext[MB-1]; op_sel24 = 1'b0;
            end
            default: begin
                op_m = '0; op_g = '0; op_neg = 1'b0; op_sel24 = 1'b0;
            end
        endcase
    end

    // Low partial product, shifted down when it is registered
    logic [sprc_pkg::PLO_BITS-1:0] plo;
    assign plo = op_m[sprc_pkg::MLO_BITS-1:0] * op_g;

    // Recombine partial products and saturate with sign
    logic [sprc_pkg::WSUM_BITS-2:0] hi_sh;
    logic [sprc_pkg::WSUM_BITS-1:0] wsum;
    logic                           over;
    logic [RB-1:0]                  mag_r;
    logic signed [RB-1:0]           mul_res;

    assign hi_sh = sel24_reg ? {8'b0, hi_reg, 8'b0} : {hi_reg, 16'b0};
    assign wsum  = {1'b0, hi_sh} +
                   {{(sprc_pkg::WSUM_BITS-sprc_pkg::LO_BITS){1'b0}}, lo_reg};
    assign over  = wsum > RMAX_W;
    assign mag_r = wsum[RB-1:0];

    always_comb begin
        if (neg_reg) begin
            mul_res = over ? RMIN_S : signed'(RB'(-mag_r));
        end else begin
            mul_res = over ? RMAX_S : signed'(mag_r);
        end
    end

    // Loop arithmetic
    logic signed [RB+1:0] trav_sum, err_diff, acc_sum, pid_sum;
    logic signed [RB-1:0] pid_r;
    logic [RB:0]          err_mag, pid_mag, res_mag, rate_mag;

    assign trav_sum = (RB+2)'(travel_reg) + (RB+2)'(mul_res);
    assign err_diff = (RB+2)'(target_reg) - (RB+2)'(travel_reg);
    assign acc_sum  = (RB+2)'(accum_reg) + (RB+2)'(err_reg);
    assign pid_sum  = psum_reg + (RB+2)'(mul_res);
    assign pid_r    = sat_rate(pid_sum);
    assign err_mag  = err_reg[RB-1] ? (RB+1)'(-(RB+1)'(err_reg)) : (RB+1)'(err_reg);
    assign pid_mag  = pid_r[RB-1] ? (RB+1)'(-(RB+1)'(pid_r)) : (RB+1)'(pid_r);
    assign res_mag  = mul_res[RB-1] ? (RB+1)'(-(RB+1)'(mul_res)) : (RB+1)'(mul_res);
    assign rate_mag = rate_reg[RB-1] ? (RB+1)'(-(RB+1)'(rate_reg)) : (RB+1)'(rate_reg);

    // Status to the controller
    assign status.seek       = (seek_reg == sprc_pkg::CMD_SEEK);
    assign status.enable     = enable_reg;
    assign status.throw_rate = rate_mag > (RB+1)'(sprc_pkg::THROW_MIN);
    assign status.below      = paused_reg ? (res_mag <= (RB+1)'(sprc_pkg::THR_PAUSED_MAX))
                                          : (res_mag <  (RB+1)'(sprc_pkg::THR_PLAYING));

    assign out_rate = out_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_scale_reg    <= 32'd4194304;
            gain_p_reg        <= 32'sd19661;
            gain_i_reg        <= '0;
            gain_d_reg        <= '0;
            decay_paused_reg  <= 16'd58897;
            decay_playing_reg <= 16'd62128;
            dead_band_reg     <= 31'd66;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sprc_pkg::CFG_NORM_SCALE:    norm_scale_reg    <= cfg_data;
                sprc_pkg::CFG_GAIN_P:        gain_p_reg        <= signed'(cfg_data);
                sprc_pkg::CFG_GAIN_I:        gain_i_reg        <= signed'(cfg_data);
                sprc_pkg::CFG_GAIN_D:        gain_d_reg        <= signed'(cfg_data);
                sprc_pkg::CFG_DECAY_PAUSED:  decay_paused_reg  <= cfg_data[15:0];
                sprc_pkg::CFG_DECAY_PLAYING: decay_playing_reg <= cfg_data[15:0];
                sprc_pkg::CFG_DEAD_BAND:     dead_band_reg     <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Latch the input transaction
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cur_reg    <= signed'(s_tdata[PB-1:0]);
            scr_reg    <= signed'(s_tdata[2*PB-1:PB]);
            enable_reg <= s_tdata[2*PB];
            paused_reg <= s_tdata[2*PB+1];
            seek_reg   <= s_tuser;
        end
    end

    // Shared multiplier: low word, then high part
    always_ff @(posedge aclk) begin
        if (cmd.mul_lo) begin
            lo_reg    <= op_sel24 ? sprc_pkg::LO_BITS'(plo >> 24)
                                  : sprc_pkg::LO_BITS'(plo >> 16);
            mhi_reg   <= op_m[MB-1:sprc_pkg::MLO_BITS];
            g_reg     <= op_g;
            neg_reg   <= op_neg;
            sel24_reg <= op_sel24;
        end
        if (cmd.mul_hi) begin
            hi_reg <= mhi_reg * g_reg;
        end
    end

    // Loop state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg   <= '0;
            start_reg  <= '0;
            travel_reg <= '0;
            rate_reg   <= '0;
            prev_reg   <= '0;
            accum_reg  <= '0;
        end else begin
            if (cmd.init_scratch) begin
                rate_reg   <= '0;
                travel_reg <= '0;
                prev_reg   <= '0;
                accum_reg  <= '0;
                start_reg  <= scr_reg;
            end
            if (cmd.upd_travel) begin
                travel_reg <= sat_rate(trav_sum);
            end
            if (cmd.upd_accum && (err_mag > (RB+1)'(sprc_pkg::ERR_INTEG_MIN))) begin
                accum_reg <= sat_rate(acc_sum);
            end
            if (cmd.finish_pid) begin
                rate_reg <= (pid_mag < (RB+1)'(dead_band_reg)) ? '0 : pid_r;
                prev_reg <= err_reg;
            end
            if (cmd.set_decay) begin
                rate_reg <= mul_res;
            end
            if (cmd.upd_last) begin
                last_reg <= cur_reg;
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.set_target) begin
            target_reg <= mul_res;
        end
        if (cmd.upd_err) begin
            err_reg <= sat_rate(err_diff);
        end
        if (cmd.psum_load) begin
            psum_reg <= (RB+2)'(mul_res);
        end else if (cmd.psum_add) begin
            psum_reg <= pid_sum;
        end
        if (cmd.load_out) begin
            out_reg <= rate_reg;
        end
    end

endmodule

/* rtl/sprc_ctrl.sv */
// Controller: scratch state flags, operation sequencer and output handshake.
module sprc_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sprc_pkg::M_TUSER_BITS-1:0]  m_tuser,
    output sprc_pkg::ctrl_cmd_t                cmd,
    input  sprc_pkg::dp_status_t               status
);

    sprc_pkg::state_t state_reg, state_next;
    logic active_reg, active_next;
    logic coasting_reg, coasting_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [sprc_pkg::M_TUSER_BITS-1:0] m_tuser_reg, m_tuser_next;
    logic out_free;

    assign s_tready = (state_reg == sprc_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequence the operations of one transaction
    always_comb begin
        state_next    = state_reg;
        active_next   = active_reg;
        coasting_next = coasting_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.mul_op    = sprc_pkg::MOP_TGT;

        unique case (state_reg)
            sprc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = sprc_pkg::ST_DISPATCH;
                end
            end
            sprc_pkg::ST_DISPATCH: begin
                priority if (status.seek) begin
                    state_next = sprc_pkg::ST_OUT;
                end else if (!active_reg) begin
                    if (status.enable) begin
                        cmd.init_scratch = 1'b1;
                        active_next      = 1'b1;
                        coasting_next    = 1'b0;
                    end
                    state_next = sprc_pkg::ST_OUT;
                end else if (coasting_reg) begin
                    state_next = sprc_pkg::ST_DEC_L;
                end else if (status.enable) begin
                    state_next = sprc_pkg::ST_TGT_L;
                end else begin
                    // release: throw into inertia or stop
                    if (status.throw_rate) begin
                        coasting_next = 1'b1;
                    end else begin
                        active_next = 1'b0;
                    end
                    state_next = sprc_pkg::ST_OUT;
                end
            end
            sprc_pkg::ST_TGT_L: begin
                cmd.mul_lo = 1'b1;
                cmd.mul_op = sprc_pkg::MOP_TGT;
                state_next = sprc_pkg::ST_TGT_H;
            end
            sprc_pkg::ST_TGT_H: begin
                cmd.mul_hi = 1'b1;
                state_next = sprc_pkg::ST_TRV_L;
            end
            sprc_pkg::ST_TRV_L: begin
                cmd.set_target = 1'b1;
                cmd.mul_lo     = 1'b1;
                cmd.mul_op     = sprc_pkg::MOP_TRV;
                state_next     = sprc_pkg::ST_TRV_H;
            end
            sprc_pkg::ST_TRV_H: begin
                cmd.mul_hi = 1'b1;
                state_next = sprc_pkg::ST_TRV_DONE;
            end
            sprc_pkg::ST_TRV_DONE: begin
                cmd.upd_travel = 1'b1;
                state_next     = sprc_pkg::ST_ERR;
            end
            sprc_pkg::ST_ERR: begin
                cmd.upd_err = 1'b1;
                state_next  = sprc_pkg::ST_P_L;
            end
            sprc_pkg::ST_P_L: begin
                cmd.upd_accum = 1'b1;
                cmd.mul_lo    = 1'b1;
                cmd.mul_op    = sprc_pkg::MOP_P;
                state_next    = sprc_pkg::ST_P_H;
            end
            sprc_pkg::ST_P_H: begin
                cmd.mul_hi = 1'b1;
                state_next = sprc_pkg::ST_I_L;
            end
            sprc_pkg::ST_I_L: begin
                cmd.psum_load = 1'b1;
                cmd.mul_lo    = 1'b1;
                cmd.mul_op    = sprc_pkg::MOP_I;
                state_next    = sprc_pkg::ST_I_H;
            end
            sprc_pkg::ST_I_H: begin
                cmd.mul_hi = 1'b1;
                state_next = sprc_pkg::ST_D_L;
            end
            sprc_pkg::ST_D_L: begin
                cmd.psum_add = 1'b1;
                cmd.mul_lo   = 1'b1;
                cmd.mul_op   = sprc_pkg::MOP_D;
                state_next   = sprc_pkg::ST_D_H;
            end
            sprc_pkg::ST_D_H: begin
                cmd.mul_hi = 1'b1;
                state_next = sprc_pkg::ST_SUM;
            end
            sprc_pkg::ST_SUM: begin
                cmd.finish_pid = 1'b1;
                state_next     = sprc_pkg::ST_OUT;
            end
            sprc_pkg::ST_DEC_L: begin
                cmd.mul_lo = 1'b1;
                cmd.mul_op = sprc_pkg::MOP_DEC;
                state_next = sprc_pkg::ST_DEC_H;
            end
            sprc_pkg::ST_DEC_H: begin
                cmd.mul_hi = 1'b1;
                state_next = sprc_pkg::ST_DEC_END;
            end
            sprc_pkg::ST_DEC_END: begin
                cmd.set_decay = 1'b1;
                if (status.below || status.enable) begin
                    active_next   = 1'b0;
                    coasting_next = 1'b0;
                end
                state_next = sprc_pkg::ST_OUT;
            end
            sprc_pkg::ST_OUT: begin
                // re-base the last position, then hand over the result
                cmd.upd_last = 1'b1;
                if (out_free) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = {coasting_reg, active_reg};
                    state_next    = sprc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sprc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sprc_pkg::ST_IDLE;
            active_reg   <= 1'b0;
            coasting_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tuser_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            coasting_reg <= coasting_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

endmodule

/* rtl/scratch_position_rate_controller.sv */
// Throughput: one transaction in flight; the next is taken on the cycle after
// the result is loaded into the output register. The shared split multiplier
// (two passes per product, five products per scratching tick) makes a
// scratching tick the longest kind of transaction.
// Reset: synchronous active-low aresetn clears state and restores registers.
module scratch_position_rate_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [47:0] current_position, [95:48] scratch_target,
    // [96] scratch_enable, [97] paused, [103:98] zero
    input  logic [sprc_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // [0] command
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] rate
    output logic [sprc_pkg::M_TDATA_BITS-1:0]   m_tdata,
    // [0] scratching, [1] inertia
    output logic [sprc_pkg::M_TUSER_BITS-1:0]   m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sprc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [sprc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    sprc_pkg::ctrl_cmd_t  cmd;
    sprc_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    sprc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

    sprc_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_rate  (m_tdata)
    );

endmodule

/* rtl/sprc_checker.sv */
// Port-level checks for the scratch position rate controller, with bind.
module sprc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [sprc_pkg::M_TDATA_BITS-1:0]   m_tdata,
    input logic [sprc_pkg::M_TUSER_BITS-1:0]   m_tuser
);

    // Inertia only ever shows together with scratching
    a_inertia_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] || !m_tuser[1]))
        else $error("inertia flagged without scratching");

    // One transaction at a time: no accept straight after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind scratch_position_rate_controller sprc_checker u_sprc_checker (.*);

/* tb/sv/tb_scratch_position_rate_controller.sv */
// Self-checking testbench of the scratch position rate controller.
`timescale 1ns / 100ps

module tb_scratch_position_rate_controller;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 1100;
    localparam longint RATE_MAX   = 64'sd2147483647;
    localparam longint RATE_MIN   = -64'sd2147483648;
    localparam longint WIDE_CAP   = 64'sd1 << 48;

    // One tick or seek as seen on the input stream
    typedef struct packed {
        logic                cmd;
        logic signed [47:0]  cur_pos;
        logic signed [47:0]  scr_pos;
        logic                enable;
        logic                paused;
    } tick_t;

    // One rate result
    typedef struct packed {
        logic [31:0] rate;
        logic        scratching;
        logic        inertia;
    } rate_res_t;

    // Directed row: stimulus plus optional typed-in result
    typedef struct packed {
        tick_t     tick;
        logic      has_res;
        rate_res_t res;
    } dir_row_t;

    logic                                  aclk = 1'b0;
    logic                                  aresetn = 1'b0;
    logic                                  s_tvalid = 1'b0;
    logic                                  s_tready;
    logic [sprc_pkg::S_TDATA_BITS-1:0]     s_tdata = '0;
    logic                                  s_tuser = 1'b0;
    logic                                  m_tvalid;
    logic                                  m_tready = 1'b0;
    logic [sprc_pkg::M_TDATA_BITS-1:0]     m_tdata;
    logic [sprc_pkg::M_TUSER_BITS-1:0]     m_tuser;
    logic                                  cfg_valid = 1'b0;
    logic                                  cfg_ready;
    logic [sprc_pkg::CFG_IDX_BITS-1:0]     cfg_index = '0;
    logic [sprc_pkg::CFG_DATA_BITS-1:0]    cfg_data = '0;

    // Predictor state and register copy
    logic         pr_active, pr_coast;
    longint       pr_last, pr_start, pr_travel, pr_rate, pr_perr, pr_accum;
    longint       rg_norm, rg_gp, rg_gi, rg_gd, rg_decp, rg_decr, rg_dband;

    rate_res_t    rate_queue[$];
    int           fail_count = 0;
    int           res_count = 0;
    int           idle_cycles = 0;
    int           coast_seen = 0;
    int           scratch_seen = 0;
    bit           stall_mode = 1'b0;

    scratch_position_rate_controller i_dut (.*);

    always #2 aclk = ~aclk;

    function automatic longint clamp_rate(longint x);
        if (x > RATE_MAX) return RATE_MAX;
        if (x < RATE_MIN) return RATE_MIN;
        return x;
    endfunction

    function automatic longint abs_val(longint a);
        return a < 0 ? -a : a;
    endfunction

    // (m * g) >> sh, capped at 2^48
    function automatic longint scaled_mag(longint m, longint g, int sh);
        logic [127:0] prod;
        prod = ({64'd0, m} * {64'd0, g}) >> sh;
        if (prod > 128'(WIDE_CAP)) return WIDE_CAP;
        return longint'(prod[63:0]);
    endfunction

    function automatic longint apply_sign(longint mag, logic neg);
        if (neg) return (mag > RATE_MAX) ? RATE_MIN : -mag;
        return (mag > RATE_MAX) ? RATE_MAX : mag;
    endfunction

    function automatic longint gain_mul(longint a, longint g);
        return apply_sign(scaled_mag(abs_val(a), abs_val(g), 16), (a < 0) != (g < 0));
    endfunction

    function automatic longint norm_dist(longint a, longint b);
        return apply_sign(scaled_mag(abs_val(a - b), rg_norm, 24), a < b);
    endfunction

    task automatic reset_predictor();
        pr_active = 0; pr_coast = 0;
        pr_last = 0; pr_start = 0; pr_travel = 0; pr_rate = 0; pr_perr = 0; pr_accum = 0;
        rg_norm = 4194304; rg_gp = 19661; rg_gi = 0; rg_gd = 0;
        rg_decp = 58897; rg_decr = 62128; rg_dband = 66;
    endtask

    // Advance the predictor by one transaction and return the expected result
    function automatic rate_res_t predict_rate(tick_t t);
        longint cur, scr, dec, tgt, err, r, m;
        logic   below;
        rate_res_t res;
        cur = longint'(t.cur_pos);
        scr = longint'(t.scr_pos);
        if (t.cmd == sprc_pkg::CMD_TICK) begin
            if (pr_active && pr_coast) begin
                dec = t.paused ? rg_decp : rg_decr;
                pr_rate = apply_sign(scaled_mag(abs_val(pr_rate), dec, 16), pr_rate < 0);
                m = abs_val(pr_rate);
                below = t.paused ? (m <= sprc_pkg::THR_PAUSED_MAX)
                                 : (m < sprc_pkg::THR_PLAYING);
                if (below || t.enable) begin
                    pr_coast = 0;
                    pr_active = 0;
                end
            end else if (pr_active && t.enable) begin
                tgt = norm_dist(scr, pr_start);
                pr_travel = clamp_rate(pr_travel + norm_dist(cur, pr_last));
                err = clamp_rate(tgt - pr_travel);
                if (abs_val(err) > sprc_pkg::ERR_INTEG_MIN)
                    pr_accum = clamp_rate(pr_accum + err);
                r = clamp_rate(gain_mul(err, rg_gp) + gain_mul(pr_accum, rg_gi)
                               + gain_mul(err - pr_perr, rg_gd));
                if (abs_val(r) < rg_dband) r = 0;
                pr_rate = r;
                pr_perr = err;
            end else if (pr_active) begin
                if (abs_val(pr_rate) > sprc_pkg::THROW_MIN) pr_coast = 1;
                else pr_active = 0;
            end else if (t.enable) begin
                pr_active = 1; pr_coast = 0;
                pr_rate = 0; pr_travel = 0; pr_start = scr; pr_perr = 0; pr_accum = 0;
            end
        end
        pr_last = cur;
        res.rate = pr_rate[31:0];
        res.scratching = pr_active;
        res.inertia = pr_coast;
        return res;
    endfunction

    // Hand one transaction to the block, with random burst gaps
    task automatic send_tick(tick_t t);
        if ($urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= t.cmd;
        s_tdata  <= {6'd0, t.paused, t.enable, t.scr_pos, t.cur_pos};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(sprc_pkg::cfg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            sprc_pkg::CFG_NORM_SCALE:    rg_norm  = longint'({32'd0, val});
            sprc_pkg::CFG_GAIN_P:        rg_gp    = longint'($signed(val));
            sprc_pkg::CFG_GAIN_I:        rg_gi    = longint'($signed(val));
            sprc_pkg::CFG_GAIN_D:        rg_gd    = longint'($signed(val));
            sprc_pkg::CFG_DECAY_PAUSED:  rg_decp  = longint'({48'd0, val[15:0]});
            sprc_pkg::CFG_DECAY_PLAYING: rg_decr  = longint'({48'd0, val[15:0]});
            sprc_pkg::CFG_DEAD_BAND:     rg_dband = longint'({33'd0, val[30:0]});
            default: ;
        endcase
    endtask

    // Hold until every expected result has arrived, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (rate_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic push_tick(tick_t t);
        rate_queue.push_back(predict_rate(t));
        send_tick(t);
    endtask

    function automatic logic signed [47:0] rand_pos();
        case ($urandom_range(0, 3))
            0:       return 48'({$urandom, $urandom});
            1:       return $urandom_range(0, 1) ? 48'sh7FFF_FFFF_FFFF : 48'sh8000_0000_0000;
            default: return 48'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    // Well-formed scratch gesture: grab, drag, release, coast or stop
    task automatic scratch_gesture(output int sent);
        tick_t t;
        longint pos, scr;
        int n;
        sent = 0;
        pos = longint'($signed($urandom_range(0, 1 << 20))) - (1 << 19);
        scr = pos;
        t.paused = 1'($urandom_range(0, 1));
        n = $urandom_range(2, 20);
        for (int k = 0; k < n; k++) begin
            t.cmd = ($urandom_range(0, 15) == 0) ? sprc_pkg::CMD_SEEK : sprc_pkg::CMD_TICK;
            t.enable = 1'b1;
            scr += longint'($signed($urandom_range(0, 60000))) - 30000;
            pos += longint'($signed($urandom_range(0, 20000))) - 10000;
            t.cur_pos = pos[47:0];
            t.scr_pos = scr[47:0];
            push_tick(t);
            sent++;
        end
        n = $urandom_range(1, 40);
        for (int k = 0; k < n; k++) begin
            t.cmd = sprc_pkg::CMD_TICK;
            t.enable = ($urandom_range(0, 30) == 0);
            if ($urandom_range(0, 7) == 0) t.paused = ~t.paused;
            pos += $urandom_range(0, 2000);
            t.cur_pos = pos[47:0];
            push_tick(t);
            sent++;
        end
    endtask

    // Check each accepted result against the oldest expectation
    always @(posedge aclk) begin
        rate_res_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            res_count++;
            if (m_tuser[1]) coast_seen++;
            if (m_tuser[0]) scratch_seen++;
            if (rate_queue.size() == 0) begin
                $error("unexpected result rate=%h tuser=%b", m_tdata, m_tuser);
                fail_count++;
            end else begin
                exp_res = rate_queue.pop_front();
                if (m_tdata !== exp_res.rate) begin
                    $error("rate: expected %h actual %h", exp_res.rate, m_tdata);
                    fail_count++;
                end
                if (m_tuser[0] !== exp_res.scratching) begin
                    $error("scratching: expected %b actual %b", exp_res.scratching, m_tuser[0]);
                    fail_count++;
                end
                if (m_tuser[1] !== exp_res.inertia) begin
                    $error("inertia: expected %b actual %b", exp_res.inertia, m_tuser[1]);
                    fail_count++;
                end
            end
        end
    end

    // Stall the result side on its own pattern
    always @(posedge aclk) begin
        if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
        m_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // Watchdog on cycles with no transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_scratch_position_rate_controller failed");
            $finish;
        end
    end

    initial begin
        dir_row_t rows[$];
        dir_row_t row;
        tick_t    t;
        rate_res_t got;
        int       sent;

        reset_predictor();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: seek and idle ticks after reset, extremes, a short scratch
        row = '0;
        row.tick = '{sprc_pkg::CMD_SEEK, 48'sh7FFF_FFFF_FFFF, 48'sh8000_0000_0000, 1'b1, 1'b1};
        row.has_res = 1; row.res = '{32'd0, 1'b0, 1'b0}; rows.push_back(row);
        row.tick = '{sprc_pkg::CMD_TICK, 48'sh8000_0000_0000, 48'sh7FFF_FFFF_FFFF, 1'b0, 1'b0};
        row.has_res = 1; row.res = '{32'd0, 1'b0, 1'b0}; rows.push_back(row);
        row.tick = '{sprc_pkg::CMD_TICK, 48'sh0, 48'sh8000_0000_0000, 1'b1, 1'b0};
        row.has_res = 1; row.res = '{32'd0, 1'b1, 1'b0}; rows.push_back(row);
        row.has_res = 0;
        row.tick = '{sprc_pkg::CMD_TICK, 48'sh0, 48'sh7FFF_FFFF_FFFF, 1'b1, 1'b0};
        rows.push_back(row);
        row.tick = '{sprc_pkg::CMD_TICK, 48'sh7FFF_FFFF_FFFF, 48'sh0, 1'b1, 1'b1};
        rows.push_back(row);
        row.tick = '{sprc_pkg::CMD_SEEK, 48'sh100, 48'sh0, 1'b1, 1'b0}; rows.push_back(row);
        row.tick = '{sprc_pkg::CMD_TICK, 48'sh200, 48'sh7FFF_FFFF_FFFF, 1'b1, 1'b0};
        rows.push_back(row);
        // release at high rate: inertia on playing, then on paused
        for (int k = 0; k < 10; k++) begin
            row.tick = '{sprc_pkg::CMD_TICK, 48'(k), 48'sh0, 1'b0, 1'(k > 5)};
            rows.push_back(row);
        end
        row.tick = '{sprc_pkg::CMD_TICK, 48'sh0, 48'sh1000, 1'b1, 1'b0}; rows.push_back(row);
        row.tick = '{sprc_pkg::CMD_TICK, 48'sh0, 48'sh1000, 1'b1, 1'b0}; rows.push_back(row);
        row.tick = '{sprc_pkg::CMD_TICK, 48'sh0, 48'sh1000, 1'b0, 1'b0}; rows.push_back(row);
        foreach (rows[k]) begin
            got = predict_rate(rows[k].tick);
            rate_queue.push_back(rows[k].has_res ? rows[k].res : got);
            send_tick(rows[k].tick);
        end
        drain();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(sprc_pkg::CFG_NORM_SCALE, ph == 0 ? 32'hFFFF_FFFF : ph == 1 ? 32'd0 :
                      ($urandom_range(0, 1) ? 32'd4194304 : $urandom));
            write_reg(sprc_pkg::CFG_GAIN_P, ph == 0 ? 32'h7FFF_FFFF : ph == 2 ? 32'h8000_0000 :
                      32'($urandom_range(0, 131072)) - 32'd16384);
            write_reg(sprc_pkg::CFG_GAIN_I, ph == 0 ? 32'h8000_0000 : ph == 3 ? 32'h7FFF_FFFF :
                      32'($urandom_range(0, 2000)) - 32'd1000);
            write_reg(sprc_pkg::CFG_GAIN_D, ph == 0 ? 32'h7FFF_FFFF : ph == 4 ? 32'h8000_0000 :
                      32'($urandom_range(0, 20000)) - 32'd10000);
            write_reg(sprc_pkg::CFG_DECAY_PAUSED, ph == 0 ? 32'hFFFF : ph == 5 ? 32'd0 :
                      32'($urandom_range(40000, 65535)));
            write_reg(sprc_pkg::CFG_DECAY_PLAYING, ph == 0 ? 32'hFFFF : ph == 6 ? 32'd0 :
                      32'($urandom_range(40000, 65535)));
            write_reg(sprc_pkg::CFG_DEAD_BAND, ph == 0 ? 32'h7FFF_FFFF : ph == 7 ? 32'd0 :
                      32'($urandom_range(0, 70000)));
            cfg_valid <= 1'b0;
            for (int n = 0; n < RANDOM_ITEMS / 8; ) begin
                if ($urandom_range(0, 4) != 0) begin
                    scratch_gesture(sent);
                    n += sent;
                end else begin
                    t.cmd = 1'($urandom_range(0, 1));
                    t.cur_pos = rand_pos();
                    t.scr_pos = rand_pos();
                    t.enable = 1'($urandom_range(0, 1));
                    t.paused = 1'($urandom_range(0, 1));
                    push_tick(t);
                    n++;
                end
            end
            drain();
        end

        $display("Covered %0d results: %0d while scratching, %0d in inertia, 8 register settings.",
                 res_count, scratch_seen, coast_seen);
        if (fail_count == 0)
            $display("tb_scratch_position_rate_controller passed");
        else
            $display("tb_scratch_position_rate_controller failed");
        $finish;
    end
endmodule

/* scratch_position_rate_controller.f */
rtl/sprc_pkg.sv
rtl/sprc_dpath.sv
rtl/sprc_ctrl.sv
rtl/scratch_position_rate_controller.sv
rtl/sprc_checker.sv
tb/sv/tb_scratch_position_rate_controller.sv
